>>> rtl/gle_pkg.sv
package gle_pkg;

  // Window geometry and pattern lengths.
  localparam int WIN_DEPTH = 16;
  localparam int IDX_W     = $clog2(WIN_DEPTH);
  localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
  localparam int HDR_LEN   = 16;
  localparam int DESC_LEN  = 5;
  localparam int EXT_LEN   = 19;
  localparam int EXT_W     = $clog2(EXT_LEN + 1);
  localparam int KEEP_LEN  = DESC_LEN - 1;
  localparam int DROP_LEN  = 3;

  // Edit mode codes; the unused code behaves as pass.
  localparam logic [1:0] MODE_REMOVE = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_PASS   = 2'd2;

  // NETSCAPE2.0 looping extension header.
  localparam logic [7:0] LOOP_HDR [HDR_LEN] = '{
    8'h21, 8'hFF, 8'h0B, 8'h4E, 8'h45, 8'h54, 8'h53, 8'h43,
    8'h41, 8'h50, 8'h45, 8'h32, 8'h2E, 8'h30, 8'h03, 8'h01};

  // Image descriptor prefix.
  localparam logic [7:0] DESC_PREFIX [DESC_LEN] = '{
    8'h2C, 8'h00, 8'h00, 8'h00, 8'h00};

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic hdr_hit;
    logic desc_hit;
  } match_t;

  // Output source request from the control logic to the output register.
  typedef struct packed {
    logic      req;
    out_item_t item;
  } src_t;

  // Byte of the infinite-loop extension: the header, then three zero bytes.
  function automatic logic [7:0] ext_byte(input logic [EXT_W-1:0] idx);
    logic [7:0] res;
    res = 8'h00;
    if (idx < EXT_W'(HDR_LEN)) begin
      res = LOOP_HDR[idx[IDX_W-1:0]];
    end
    return res;
  endfunction

endpackage

>>> rtl/gle_match.sv
module gle_match (
  input  gle_pkg::win_t   win,
  output gle_pkg::match_t hit
);
  import gle_pkg::*;

  // Parallel compare of the window head against both patterns.
  always_comb begin
    hit.hdr_hit  = 1'b1;
    hit.desc_hit = 1'b1;
    for (int i = 0; i < HDR_LEN; i++) begin
      if (win[i] != LOOP_HDR[i]) begin
        hit.hdr_hit = 1'b0;
      end
    end
    for (int i = 0; i < DESC_LEN; i++) begin
      if (win[i] != DESC_PREFIX[i]) begin
        hit.desc_hit = 1'b0;
      end
    end
  end

endmodule

>>> rtl/gle_out_stage.sv
module gle_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  gle_pkg::src_t      src,
  output logic               load_en,
  output logic               out_valid,
  input  logic               out_ready,
  output gle_pkg::out_item_t out_item
);
  import gle_pkg::*;

  logic      out_valid_r;
  out_item_t out_item_r;

  // The register takes a new item when empty or when its item is taken.
  assign load_en   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_en) begin
      out_valid_r <= src.req;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load_en && src.req) begin
      out_item_r <= src.item;
    end
  end

endmodule

>>> rtl/gif_loop_extension_editor.sv
// Streaming GIF loop-extension editor. One file byte enters per item and, while
// out_ready is high, one edited byte leaves per cycle. cfg_wr_data selects the edit:
// 0 removes the first NETSCAPE2.0 looping extension (its 16-byte header and the 3 bytes
// after it), 1 inserts a 19-byte infinite-loop extension in front of the first image
// descriptor, 2 or 3 copies bytes unchanged. Only the first match in each file is
// edited. In steady state the block takes one item per cycle while out_ready is high.
// The single output port sets the exceptions: an insertion holds the input while the
// extension and all but the last of the five held descriptor bytes go out, the final
// item of a file holds it until the bytes still in the 16-byte lookahead window and the
// file's last item have moved into the output register, and a switch to insert mode in
// the middle of a file holds it while the surplus window bytes drain. A file whose edit
// drops every trailing byte ends in a bare end marker (out_valid field 0, out_last 1).
module gif_loop_extension_editor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  gle_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output gle_pkg::out_item_t out_item
);
  import gle_pkg::*;

  // Window buffer: the front cmt_r entries are released and waiting for the port.
  win_t             buf_r, buf_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] cmt_r, cmt_nxt;
  logic [EXT_W-1:0] ins_r, ins_nxt;
  logic [1:0]       drop_r, drop_nxt;
  logic             done_r, done_nxt;
  logic             eof_r, eof_nxt;
  logic [1:0]       mode_r;

  logic             load_en;
  logic             pop;
  logic             acc;
  src_t             src;
  logic [EXT_W-1:0] ins_adv;
  logic             eof_adv;
  win_t             buf_pop;
  win_t             base;
  win_t             win_app;
  logic [CNT_W-1:0] fill_base;
  logic [CNT_W-1:0] cmt_base;
  logic [CNT_W-1:0] app_fill;
  match_t           hit;

  gle_match u_match (
    .win (win_app),
    .hit (hit)
  );

  gle_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .src       (src),
    .load_en   (load_en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // Output source: extension bytes first, then released window bytes, then the end marker.
  always_comb begin
    src      = '0;
    pop      = 1'b0;
    eof_adv  = eof_r;
    ins_adv  = ins_r;
    if (ins_r != '0) begin
      src.req            = 1'b1;
      src.item.out_byte  = ext_byte(EXT_W'(EXT_LEN) - ins_r);
      src.item.out_valid = 1'b1;
      if (load_en) begin
        ins_adv = ins_r - EXT_W'(1);
      end
    end else if (cmt_r != '0) begin
      src.req            = 1'b1;
      src.item.out_byte  = buf_r[0];
      src.item.out_valid = 1'b1;
      src.item.out_last  = eof_r && (cmt_r == CNT_W'(1));
      pop                = load_en;
      if (load_en && src.item.out_last) begin
        eof_adv = 1'b0;
      end
    end else if (eof_r) begin
      src.req           = 1'b1;
      src.item.out_last = 1'b1;
      if (load_en) begin
        eof_adv = 1'b0;
      end
    end
  end

  // Buffer view after this cycle's pop, with the incoming byte appended.
  always_comb begin
    for (int i = 0; i < WIN_DEPTH - 1; i++) begin
      buf_pop[i] = buf_r[i+1];
    end
    buf_pop[WIN_DEPTH-1] = buf_r[WIN_DEPTH-1];
    base      = pop ? buf_pop : buf_r;
    fill_base = fill_r - CNT_W'(pop);
    cmt_base  = cmt_r - CNT_W'(pop);
    win_app   = base;
    win_app[fill_base[IDX_W-1:0]] = in_item.in_byte;
    app_fill  = fill_base + CNT_W'(1);
  end

  // An item enters once no extension byte or end of file is pending and all released bytes are gone or leaving.
  assign in_ready = (ins_r == '0) && !eof_r && (cmt_base == '0);
  assign acc      = in_valid && in_ready;

  // Edit decision for the accepted item.
  always_comb begin
    buf_nxt  = base;
    fill_nxt = fill_base;
    cmt_nxt  = cmt_base;
    drop_nxt = drop_r;
    done_nxt = done_r;
    ins_nxt  = ins_adv;
    eof_nxt  = eof_adv;
    if (acc) begin
      if (drop_r != '0) begin
        drop_nxt = drop_r - 2'd1;
      end else begin
        buf_nxt  = win_app;
        fill_nxt = app_fill;
        if (done_r || mode_r[1]) begin
          cmt_nxt = app_fill;
        end else if (mode_r == MODE_REMOVE) begin
          if (app_fill == CNT_W'(HDR_LEN)) begin
            if (hit.hdr_hit) begin
              fill_nxt = '0;
              drop_nxt = 2'(DROP_LEN);
              done_nxt = 1'b1;
            end else begin
              cmt_nxt = CNT_W'(1);
            end
          end
        end else begin
          if (app_fill == CNT_W'(DESC_LEN)) begin
            if (hit.desc_hit) begin
              ins_nxt  = EXT_W'(EXT_LEN);
              cmt_nxt  = app_fill;
              done_nxt = 1'b1;
            end else begin
              cmt_nxt = CNT_W'(1);
            end
          end else if ((app_fill > CNT_W'(DESC_LEN)) && !in_item.in_last) begin
            cmt_nxt = app_fill - CNT_W'(KEEP_LEN);
          end
        end
        if (in_item.in_last) begin
          cmt_nxt = fill_nxt;
        end
      end
      // End of file releases everything and rearms the edit for the next file.
      if (in_item.in_last) begin
        eof_nxt  = 1'b1;
        done_nxt = 1'b0;
        drop_nxt = '0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      cmt_r  <= '0;
      ins_r  <= '0;
      drop_r <= '0;
      done_r <= 1'b0;
      eof_r  <= 1'b0;
      mode_r <= MODE_REMOVE;
    end else begin
      fill_r <= fill_nxt;
      cmt_r  <= cmt_nxt;
      ins_r  <= ins_nxt;
      drop_r <= drop_nxt;
      done_r <= done_nxt;
      eof_r  <= eof_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
  end

  // Window bytes carry no reset.
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

>>> test/tb_gif_loop_extension_editor.sv
module tb_gif_loop_extension_editor;
  timeunit 1ns;
  timeprecision 1ps;

  import gle_pkg::*;

  // The unused mode code, which the block treats as pass.
  localparam logic [1:0] MODE_ALT_PASS = 2'd3;
  // Cycles to let the block settle before a mode write; covers a full window drain.
  localparam int SETTLE_CYCLES = 40;
  // Length of the long receiver hold-off that fills the block up.
  localparam int HOLD_CYCLES   = 300;
  // Total input items to send, and the point after which nobody idles.
  localparam int ITEM_TARGET   = 460;
  localparam int QUIET_AFTER   = 400;

  typedef struct {
    logic [1:0] mode;
    in_item_t   item;
    bit         typed;
    out_item_t  due;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = MODE_REMOVE;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Predictor state: lookahead window, edit progress and the active mode.
  logic [7:0] win_bytes [WIN_DEPTH];
  int         win_fill = 0;
  bit         edited = 1'b0;
  int         skip_left = 0;
  logic [1:0] mode_q = MODE_REMOVE;

  out_item_t  step_bytes[$];
  out_item_t  edited_bytes_due[$];
  logic [7:0] file_bytes[$];
  stim_row_t  stim_rows[$];
  out_item_t  due;

  int bad_count = 0;
  int items_sent = 0;
  bit tx_idle = 1'b1;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_active = 1'b0;

  gif_loop_extension_editor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor helpers: emit one edited byte, release the oldest window byte, flush all.
  function automatic void emit_byte(logic [7:0] b);
    step_bytes.push_back('{out_byte: b, out_valid: 1'b1, out_last: 1'b0});
  endfunction

  function automatic void release_oldest();
    if (win_fill > 0) begin
      emit_byte(win_bytes[0]);
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_bytes[i] = win_bytes[i+1];
      end
      win_fill--;
    end
  endfunction

  function automatic void release_window();
    for (int i = 0; i < win_fill; i++) begin
      emit_byte(win_bytes[i]);
    end
    win_fill = 0;
  endfunction

  // Works out the edited bytes that one input item causes, into step_bytes.
  function automatic void edit_stream_step(input in_item_t it);
    bit hit;
    step_bytes.delete();
    if (skip_left > 0) begin
      skip_left--;
    end else begin
      if (win_fill >= WIN_DEPTH) begin
        release_oldest();
      end
      win_bytes[win_fill] = it.in_byte;
      win_fill++;
      if (edited || mode_q == MODE_PASS || mode_q == MODE_ALT_PASS) begin
        release_window();
      end else if (mode_q == MODE_REMOVE) begin
        if (win_fill == HDR_LEN) begin
          hit = 1'b1;
          for (int i = 0; i < HDR_LEN; i++) begin
            if (win_bytes[i] != LOOP_HDR[i]) hit = 1'b0;
          end
          if (hit) begin
            win_fill = 0;
            skip_left = DROP_LEN;
            edited = 1'b1;
          end else begin
            release_oldest();
          end
        end
      end else begin
        if (win_fill == DESC_LEN) begin
          hit = 1'b1;
          for (int i = 0; i < DESC_LEN; i++) begin
            if (win_bytes[i] != DESC_PREFIX[i]) hit = 1'b0;
          end
          if (hit) begin
            for (int i = 0; i < EXT_LEN; i++) begin
              emit_byte((i < HDR_LEN) ? LOOP_HDR[i] : 8'h00);
            end
            release_window();
            edited = 1'b1;
          end else begin
            release_oldest();
          end
        end else if (win_fill > DESC_LEN && !it.in_last) begin
          // Mode switched to insert mid-file: drain the surplus without compare.
          while (win_fill > KEEP_LEN) release_oldest();
        end
      end
      if (it.in_last) begin
        release_window();
      end
    end
    if (it.in_last) begin
      if (step_bytes.size() == 0) begin
        step_bytes.push_back('{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b0});
      end
      step_bytes[step_bytes.size()-1].out_last = 1'b1;
      win_fill = 0;
      edited = 1'b0;
      skip_left = 0;
    end
  endfunction

  // Offers one item, after an optional idle burst, and records what it should cause.
  task automatic send_byte(input in_item_t it, input bit typed, input out_item_t typed_due);
    int gap;
    gap = (tx_idle && !quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    edit_stream_step(it);
    if (typed) begin
      edited_bytes_due.push_back(typed_due);
    end else begin
      foreach (step_bytes[i]) edited_bytes_due.push_back(step_bytes[i]);
    end
    items_sent++;
  endtask

  // Stops offering items and waits until every expected byte is out and the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (edited_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_q = m;
  endtask

  function automatic logic [1:0] pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return MODE_REMOVE;
    if (r < 8) return MODE_INSERT;
    if (r == 8) return MODE_PASS;
    return MODE_ALT_PASS;
  endfunction

  // Filler bytes lean toward the values that start or fill the patterns.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h2C;
      2: return 8'h21;
      3: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Builds one file: plain noise, or noise around a loop header or a descriptor prefix.
  // Patterns are sometimes corrupted, cut off by the end of the file, or repeated.
  function automatic void build_file(input int kind);
    int plen;
    int pos;
    int copies;
    file_bytes.delete();
    if (kind == 0) begin
      repeat ($urandom_range(1, 30)) file_bytes.push_back(noise_byte());
    end else begin
      plen = (kind == 1) ? HDR_LEN : DESC_LEN;
      copies = ($urandom_range(0, 5) == 0) ? 2 : 1;
      repeat ($urandom_range(0, 12)) file_bytes.push_back(noise_byte());
      repeat (copies) begin
        for (int i = 0; i < plen; i++) begin
          if (kind == 1) file_bytes.push_back(LOOP_HDR[i]);
          else file_bytes.push_back(DESC_PREFIX[i]);
        end
        if ($urandom_range(0, 3) == 0) begin
          pos = file_bytes.size() - plen + $urandom_range(0, plen - 1);
          file_bytes[pos] = 8'($urandom_range(0, 255));
        end
        repeat ($urandom_range(0, 8)) file_bytes.push_back(noise_byte());
      end
      if ($urandom_range(0, 5) == 0) begin
        // End the file partway into the last pattern.
        repeat ($urandom_range(1, plen - 1)) begin
          if (file_bytes.size() > 1) void'(file_bytes.pop_back());
        end
      end
    end
  endfunction

  // Sends file_bytes as one file; at split the mode is changed in the middle of it.
  task automatic send_file(input int split, input logic [1:0] new_mode);
    in_item_t it;
    foreach (file_bytes[i]) begin
      if (i == split) begin
        settle();
        set_mode(new_mode);
      end
      it.in_byte = file_bytes[i];
      it.in_last = (i == file_bytes.size() - 1);
      send_byte(it, 1'b0, '0);
    end
  endtask

  // Result checker: each edited byte against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (edited_bytes_due.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("unexpected item: byte=%h valid=%b last=%b",
                   out_item.out_byte, out_item.out_valid, out_item.out_last);
        end
      end else begin
        due = edited_bytes_due.pop_front();
        if (out_item.out_byte !== due.out_byte || out_item.out_valid !== due.out_valid ||
            out_item.out_last !== due.out_last) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("wrong item: byte=%h valid=%b last=%b, wanted byte=%h valid=%b last=%b",
                     out_item.out_byte, out_item.out_valid, out_item.out_last,
                     due.out_byte, due.out_valid, due.out_last);
          end
        end
      end
    end
  end

  // Receiver: random ready bursts, one long hold-off on request, always ready at the end.
  initial begin : rx_side
    int r;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        hold_active = 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 3) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end else begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, (r == 9) ? 80 : 15)) @(posedge clk);
        end
      end
    end
  end

  // Watchdog for a hung run.
  initial begin
    #20ms;
    $display("gif_loop_extension_editor: mismatch");
    $finish;
  end

  initial begin : stimulus
    in_item_t  it;
    out_item_t none;
    int        kind;
    int        split;
    none = '0;

    // Directed rows; expectations typed in where they are plain to see.
    it.in_last = 1'b1;
    it.in_byte = 8'h00;
    stim_rows.push_back('{MODE_PASS, it, 1'b1, '{8'h00, 1'b1, 1'b1}});
    it.in_byte = 8'hFF;
    stim_rows.push_back('{MODE_PASS, it, 1'b1, '{8'hFF, 1'b1, 1'b1}});
    it.in_byte = 8'hA5;
    stim_rows.push_back('{MODE_ALT_PASS, it, 1'b1, '{8'hA5, 1'b1, 1'b1}});
    // Loop header removed, file ends inside the dropped tail: bare end marker.
    it.in_last = 1'b0;
    for (int i = 0; i < HDR_LEN; i++) begin
      it.in_byte = LOOP_HDR[i];
      stim_rows.push_back('{MODE_REMOVE, it, 1'b0, none});
    end
    it = '{in_byte: 8'h5A, in_last: 1'b1};
    stim_rows.push_back('{MODE_REMOVE, it, 1'b1, '{8'h00, 1'b0, 1'b1}});
    // Extension inserted before a descriptor prefix, then one more byte.
    it.in_last = 1'b0;
    for (int i = 0; i < DESC_LEN; i++) begin
      it.in_byte = DESC_PREFIX[i];
      stim_rows.push_back('{MODE_INSERT, it, 1'b0, none});
    end
    it = '{in_byte: 8'h3B, in_last: 1'b1};
    stim_rows.push_back('{MODE_INSERT, it, 1'b1, '{8'h3B, 1'b1, 1'b1}});
    // Switch from remove to insert with five bytes waiting in the window.
    it.in_last = 1'b0;
    for (int i = 0; i < 5; i++) begin
      it.in_byte = 8'h11 + 8'(i);
      stim_rows.push_back('{MODE_REMOVE, it, 1'b0, none});
    end
    it.in_byte = 8'h16;
    stim_rows.push_back('{MODE_INSERT, it, 1'b0, none});
    it = '{in_byte: 8'h2C, in_last: 1'b1};
    stim_rows.push_back('{MODE_INSERT, it, 1'b0, none});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[k]) begin
      if (stim_rows[k].mode != mode_q) begin
        settle();
        set_mode(stim_rows[k].mode);
      end
      send_byte(stim_rows[k].item, stim_rows[k].typed, stim_rows[k].due);
    end

    // Long receiver hold-off while a long pass-mode file keeps coming.
    settle();
    set_mode(MODE_PASS);
    hold_req = 1'b1;
    while (!hold_active) @(posedge clk);
    tx_idle = 1'b0;
    file_bytes.delete();
    repeat (60) file_bytes.push_back(8'($urandom_range(0, 255)));
    send_file(-1, MODE_PASS);

    // Random files, mostly well-formed around the pattern that the mode looks for.
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        set_mode(pick_mode());
      end
      tx_idle = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (mode_q == MODE_REMOVE) kind = (kind < 6) ? 1 : (kind < 8) ? 0 : 2;
      else if (mode_q == MODE_INSERT) kind = (kind < 6) ? 2 : (kind < 8) ? 0 : 1;
      else kind = kind % 3;
      build_file(kind);
      split = -1;
      if (file_bytes.size() >= 8 && $urandom_range(0, 11) == 0) begin
        split = $urandom_range(1, file_bytes.size() - 1);
      end
      if (items_sent > QUIET_AFTER) quiet = 1'b1;
      send_file(split, pick_mode());
    end

    // Drain and report.
    quiet = 1'b1;
    in_valid <= 1'b0;
    while (edited_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_count == 0) begin
      $display("gif_loop_extension_editor: match");
    end else begin
      $display("gif_loop_extension_editor: mismatch");
    end
    $finish;
  end

endmodule
